### design/smav_pkg.sv
// Shared types and constants for the simple moving average block.
package smav_pkg;

  localparam int PRICE_W   = 32;
  localparam int TAG_W     = 32;
  localparam int LEN_W     = 9;
  // Sum of up to 511 samples of 32 bits.
  localparam int SUM_W     = PRICE_W + LEN_W;
  localparam int CNT_W     = $clog2(SUM_W);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   date_tag;
    logic               restart;
  } smav_in_t;

  typedef struct packed {
    logic [PRICE_W-1:0] average;
    logic [TAG_W-1:0]   result_date_tag;
  } smav_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } smav_state_t;

endpackage

### design/simple_moving_average.sv
// Simple moving average over a stream of price samples: ring memory, running sum, divider.
// Each accepted item puts its price in a ring memory with a registered read and updates a
// running sum: the sample leaving the window is read from the ring in the accept cycle and
// subtracted in the next one. Once window_length samples have arrived since the last
// restart, the sum is divided by the window length in a restoring divider that retires
// one quotient bit per cycle (41 steps), and the average leaves with the item's date tag.
// An item that gives a result goes through accept, ring update, divider and output
// hand-off; one that gives none ends after the ring update. The output register lets the
// next item be accepted while a result still waits downstream. A window_length of 0 acts
// as 1, a value above WINDOW_MAX as WINDOW_MAX. Writing window_length, or an item with
// restart set, starts a new series; the user must write only while idle (unchecked).
module simple_moving_average
  import smav_pkg::*;
#(
  parameter int WINDOW_MAX = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  smav_in_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output smav_out_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EXT_W  = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 2;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_MAX - 1);

  smav_state_t state, state_next;

  logic [LEN_W-1:0]   window_length;
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   seen;
  logic [SUM_W-1:0]   sum;
  logic [ADDR_W-1:0]  wp;
  logic               full;
  logic [PRICE_W-1:0] price;
  logic [TAG_W-1:0]   tag;

  logic [PRICE_W-1:0] ring [WINDOW_MAX];
  logic [PRICE_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [EXT_W-1:0]   oldest_ext;

  logic [SUM_W-1:0]   div_quo;
  logic [LEN_W-1:0]   div_rem;
  logic [CNT_W-1:0]   div_cnt;
  logic [LEN_W:0]     div_shift;
  logic               div_ge;

  logic               accept;
  logic               do_update;
  logic               load_out;
  logic [LEN_W-1:0]   seen_next;
  logic [SUM_W-1:0]   sum_next;
  logic               has_result;

  // Effective window length.
  always_comb begin
    eff_len = window_length;
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end
  end

  // Oldest entry of the window: (wp - len) modulo WINDOW_MAX.
  always_comb begin
    oldest_ext = EXT_W'(wp) + EXT_W'(WINDOW_MAX) - EXT_W'(eff_len);
    if (oldest_ext >= EXT_W'(WINDOW_MAX)) begin
      oldest_ext = oldest_ext - EXT_W'(WINDOW_MAX);
    end
    rd_addr = oldest_ext[ADDR_W-1:0];
  end

  // Sum and count update once the ring read returns.
  always_comb begin
    sum_next   = sum + SUM_W'(price);
    seen_next  = seen;
    if (full) begin
      sum_next = sum_next - SUM_W'(rd_data);
    end else begin
      seen_next = seen + LEN_W'(1);
    end
    has_result = (seen_next >= eff_len);
  end

  assign div_shift = {div_rem, div_quo[SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, eff_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    do_update  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept     = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        do_update  = 1'b1;
        state_next = has_result ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Ring memory: read of the oldest entry at accept, write of the new price at update.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ring[rd_addr];
    end
    if (do_update) begin
      ring[wp] <= price;
    end
  end

  // Control state of the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
      seen          <= '0;
      sum           <= '0;
      wp            <= '0;
      full          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
        seen          <= '0;
        sum           <= '0;
      end
      if (accept) begin
        full <= !in_item.restart && (seen >= eff_len);
        if (in_item.restart) begin
          seen <= '0;
          sum  <= '0;
        end
      end
      if (do_update) begin
        seen <= seen_next;
        sum  <= sum_next;
        wp   <= (wp == LAST_ADDR) ? '0 : wp + ADDR_W'(1);
      end
    end
  end

  // Item payload and restoring divider.
  always_ff @(posedge clk) begin
    if (accept) begin
      price <= in_item.price;
      tag   <= in_item.date_tag;
    end
    if (do_update) begin
      div_quo <= sum_next;
      div_rem <= '0;
      div_cnt <= CNT_W'(SUM_W - 1);
    end else if (state == ST_DIVIDE) begin
      div_quo <= {div_quo[SUM_W-2:0], div_ge};
      div_rem <= div_ge ? LEN_W'(div_shift - {1'b0, eff_len}) : div_shift[LEN_W-1:0];
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.average         <= div_quo[PRICE_W-1:0];
      out_item.result_date_tag <= tag;
    end
  end

  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_UPDATE)
    else $error("accepted item did not move to the update step");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= eff_len)
    else $error("sample count exceeds window length");

  a_divider_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && div_cnt == '0) |=> state == ST_DONE)
    else $error("divider did not finish after its last step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared without a finished division");

endmodule

### tb/tb_simple_moving_average.sv
// Self-checking testbench for the simple moving average block.
module tb_simple_moving_average
  import smav_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int WIN_MAX = 256;
  localparam int IDLE_SETTLE = 10;
  localparam int TAIL_CYCLES = 60;
  localparam int QUIET_LIMIT = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  smav_in_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  smav_out_t        out_item;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  // no idling on either side while set
  bit steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;

  // predictor state
  logic [PRICE_W-1:0] price_ring [WIN_MAX];
  logic [SUM_W-1:0]   window_total = '0;
  logic [LEN_W-1:0]   taken_count = '0;
  logic [7:0]         ring_pos = '0;
  logic [LEN_W-1:0]   window_reg = LEN_RESET;
  smav_out_t          expected_avgs [$];

  simple_moving_average #(
    .WINDOW_MAX(WIN_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic predict_average(input smav_in_t s);
    logic [LEN_W-1:0] len;
    logic [7:0]       oldest;
    logic [SUM_W-1:0] quot;
    smav_out_t        r;
    len = (window_reg == 0) ? LEN_W'(1) :
          (window_reg > WIN_MAX) ? LEN_W'(WIN_MAX) : window_reg;
    if (s.restart) begin
      taken_count = '0;
      window_total = '0;
    end
    if (taken_count >= len) begin
      // len of 256 wraps to the slot about to be overwritten
      oldest = ring_pos - len[7:0];
      window_total = window_total - price_ring[oldest];
    end else begin
      taken_count = taken_count + 1'b1;
    end
    price_ring[ring_pos] = s.price;
    window_total = window_total + s.price;
    ring_pos = ring_pos + 1'b1;
    if (taken_count >= len) begin
      quot = window_total / len;
      r.average = quot[PRICE_W-1:0];
      r.result_date_tag = s.date_tag;
      expected_avgs.push_back(r);
    end
  endtask

  function automatic smav_in_t mk_sample(input logic [31:0] p, input logic [31:0] tag,
                                         input logic rs);
    smav_in_t s;
    s.price = p;
    s.date_tag = tag;
    s.restart = rs;
    return s;
  endfunction

  function automatic logic [31:0] rand_price(input int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // valid stays high after an item; the next call either replaces the item or drops valid
  task automatic send_sample(input smav_in_t s);
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    in_item <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_average(s);
  endtask

  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_window(input int unsigned len);
    drain_results(IDLE_SETTLE);
    cfg_wr_data <= LEN_W'(len);
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_reg = LEN_W'(len);
    taken_count = '0;
    window_total = '0;
  endtask

  // default length of 20 straight out of reset
  task automatic test_reset_length();
    repeat (22) send_sample(mk_sample(rand_price(0), $urandom(), 1'b0));
  endtask

  task automatic test_single_window();
    write_window(1);
    send_sample(mk_sample(32'h0, 32'h0, 1'b0));
    send_sample(mk_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_sample(mk_sample(32'h8000_0001, 32'h55AA_55AA, 1'b1));
  endtask

  // zero acts as a length of one
  task automatic test_zero_window();
    write_window(0);
    send_sample(mk_sample(32'h1234_5678, 32'hAA55_AA55, 1'b0));
    send_sample(mk_sample(32'h7FFF_FFFF, 32'h0000_0001, 1'b0));
  endtask

  // sum past 32 bits and truncating division
  task automatic test_wide_sum();
    write_window(2);
    send_sample(mk_sample(32'hFFFF_FFFF, 32'h1, 1'b0));
    send_sample(mk_sample(32'hFFFF_FFFF, 32'h2, 1'b0));
    send_sample(mk_sample(32'h1, 32'h3, 1'b0));
    send_sample(mk_sample(32'h2, 32'h4, 1'b0));
  endtask

  task automatic test_restart_flag();
    write_window(3);
    repeat (4) send_sample(mk_sample(rand_price(0), $urandom(), 1'b0));
    send_sample(mk_sample(rand_price(0), $urandom(), 1'b1));
    repeat (3) send_sample(mk_sample(rand_price(0), $urandom(), 1'b0));
  endtask

  // a length write clears the series in progress
  task automatic test_write_mid_series();
    write_window(4);
    repeat (2) send_sample(mk_sample(rand_price(0), $urandom(), 1'b0));
    write_window(3);
    repeat (3) send_sample(mk_sample(rand_price(0), $urandom(), 1'b0));
  endtask

  // full ring, and lengths above the ring size that saturate
  task automatic test_large_windows();
    int unsigned lens [3] = '{256, 300, 511};
    foreach (lens[i]) begin
      write_window(lens[i]);
      repeat ((lens[i] > WIN_MAX) ? 262 : 270) begin
        send_sample(mk_sample(rand_price(($urandom_range(0, 9) == 0) ? 0 : 1),
                              $urandom(), 1'b0));
      end
    end
  endtask

  task automatic test_random_series();
    int unsigned sent;
    int unsigned len;
    int unsigned count;
    int unsigned mode;
    steady = 1'b1;
    write_window(5);
    repeat (150) send_sample(mk_sample(rand_price(0), $urandom(), 1'b0));
    steady = 1'b0;
    sent = 150;
    while (sent < 800) begin
      case ($urandom_range(0, 19))
        0: len = 0;
        1, 2: len = $urandom_range(13, 64);
        default: len = $urandom_range(1, 12);
      endcase
      write_window(len);
      mode = $urandom_range(0, 2);
      count = $urandom_range(len + 1, 3 * len + 12);
      repeat (count) begin
        send_sample(mk_sample(rand_price(mode), $urandom(), $urandom_range(0, 99) < 3));
      end
      sent += count;
    end
  endtask

  // output side back-pressure: single-cycle stalls plus occasional long holds
  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 499) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(30, 120);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk) begin : check_results
    smav_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_avgs.size() == 0) begin
        report_mismatch("result with nothing expected", out_item.average, '0);
      end else begin
        want = expected_avgs.pop_front();
        if (out_item.average !== want.average) begin
          report_mismatch("average", out_item.average, want.average);
        end
        if (out_item.result_date_tag !== want.result_date_tag) begin
          report_mismatch("date tag", out_item.result_date_tag, want.result_date_tag);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_length();
    test_single_window();
    test_zero_window();
    test_wide_sum();
    test_restart_flag();
    test_write_mid_series();
    test_large_windows();
    test_random_series();
    drain_results(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
